// ===== hw/rtl/lqc_pkg.sv =====
// Shared types and codes for the linear queue with cancel.
// No dependencies; imported by linear_queue_with_cancel_unit.
package lqc_pkg;

	// Command codes
	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_PROCESS = 2'd1,
		CMD_CANCEL  = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_READ     = 6'b000100,
		S_CMP      = 6'b001000,
		S_MOVE     = 6'b010000,
		S_WRITE    = 6'b100000
	} state_t;

	localparam int KEY_W = 32;

endpackage

// ===== hw/rtl/linear_queue_with_cancel_unit.sv =====
// Linear array queue of 32-bit keys with add, process (pop head) and cancel by key.
// Depends on lqc_pkg for command, status and state codes.
//
// A command is taken when start is high and busy is low; its one result appears
// on status, popped_key, queue_empty and queue_full for exactly one cycle with
// done high, and must be captured then. The keys live in a single memory with
// one write and one registered read port, and one comparator walks it under a
// small sequencer, so the steps depend on the command: add, the unused code and
// a process or cancel on an empty queue finish in the dispatch state, process
// pops the head in the compare state, and cancel compares entries from the head
// until a match or the tail and then moves each entry after the match down one
// place by a read and a write. busy stays high until the result is shown.
module linear_queue_with_cancel_unit
	import lqc_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       cmd,
	input  logic [KEY_W-1:0] ticket_key,
	output logic             done,
	output logic [1:0]       status,
	output logic [KEY_W-1:0] popped_key,
	output logic             queue_empty,
	output logic             queue_full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	state_t            state_q;
	cmd_t              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [AW-1:0]     idx_q;
	logic              empty_q;
	logic              done_q;
	status_t           status_q;
	logic [KEY_W-1:0]  popped_q;

	logic [KEY_W-1:0]  mem [DEPTH];
	logic [KEY_W-1:0]  rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [KEY_W-1:0]  mem_wdata;
	logic [AW-1:0]     mem_raddr;

	logic              full;
	logic              key_match;
	logic              accept;

	assign accept    = start && !busy;
	assign full      = !empty_q && (tail_q == LAST);
	assign key_match = (rd_q == key_q);

	// Drive memory ports from the sequencer state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rd_q;
		mem_raddr = idx_q;
		case (state_q)
			S_DISPATCH: begin
				mem_raddr = head_q;
				mem_we    = (cmd_q == CMD_ADD) && !full;
				mem_waddr = empty_q ? '0 : tail_q + AW'(1);
				mem_wdata = key_q;
			end
			S_READ: mem_raddr = idx_q;
			S_MOVE: mem_raddr = idx_q + AW'(1);
			S_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = rd_q;
			end
			default: mem_raddr = idx_q;
		endcase
	end

	// Key store: one write port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	// Sequencer and queue indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= CMD_ADD;
			key_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			idx_q    <= '0;
			empty_q  <= 1'b1;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			popped_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd_t'(cmd);
						key_q    <= ticket_key;
						status_q <= ST_OK;
						popped_q <= '0;
						state_q  <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					idx_q <= head_q;
					case (cmd_q)
						CMD_ADD: begin
							if (full) begin
								status_q <= ST_FULL;
							end else if (empty_q) begin
								head_q  <= '0;
								tail_q  <= '0;
								empty_q <= 1'b0;
							end else begin
								tail_q <= tail_q + AW'(1);
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						CMD_PROCESS, CMD_CANCEL: begin
							if (empty_q) begin
								status_q <= ST_EMPTY;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_CMP;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_READ: state_q <= S_CMP;
				S_CMP: begin
					if (cmd_q == CMD_PROCESS) begin
						// pop head
						popped_q <= rd_q;
						if (head_q >= tail_q) begin
							head_q  <= '0;
							tail_q  <= '0;
							empty_q <= 1'b1;
						end else begin
							head_q <= head_q + AW'(1);
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (key_match) begin
						if (idx_q == tail_q) begin
							// match at tail: nothing to move
							if (tail_q <= head_q) begin
								head_q  <= '0;
								tail_q  <= '0;
								empty_q <= 1'b1;
							end else begin
								tail_q <= tail_q - AW'(1);
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MOVE;
						end
					end else if (idx_q == tail_q) begin
						status_q <= ST_NOT_FOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_READ;
					end
				end
				S_MOVE: state_q <= S_WRITE;
				S_WRITE: begin
					// entry idx+1 moves down to idx
					if (idx_q + AW'(1) == tail_q) begin
						tail_q  <= tail_q - AW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_MOVE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result ports
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign popped_key  = popped_q;
	assign queue_empty = empty_q;
	assign queue_full  = full;

	// Checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted command did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held more than one cycle");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> head_q <= tail_q)
		else $error("head passed tail on a non-empty queue");

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0) && (tail_q == '0))
		else $error("empty queue with nonzero indices");

	a_popped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> popped_key == '0)
		else $error("popped key set on a failed command");

endmodule
